// File: rtl/hbi_pkg.sv
// Shared constants and an arithmetic helper for the Hermite body store.
package hbi_pkg;

  localparam int unsigned NumBodiesDefault = 64;
  localparam int unsigned BodyWidth = 6;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth = 31;

  localparam logic [2:0] KIND_LOAD = 3'd0;
  localparam logic [2:0] KIND_ACCUM = 3'd1;
  localparam logic [2:0] KIND_PREDICT = 3'd2;
  localparam logic [2:0] KIND_CORRECT = 3'd3;
  localparam logic [2:0] KIND_SAVE = 3'd4;

  localparam logic [CfgIndexWidth-1:0] REG_TIME_STEP = 1'b0;
  localparam logic [CfgIndexWidth-1:0] REG_GRAVITY = 1'b1;

  localparam logic [15:0] TimeStepReset = 16'd655;
  localparam logic [30:0] GravityReset = 31'd65536;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    begin
      hi = 48'sd2147483647;
      lo = -48'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

// File: rtl/hbi_stream_if.sv
// Valid/ready channel carrying a generic payload.
interface hbi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/hbi_mul_unit.sv
// Shared signed multiplier with scaling shift: floor(x*c / 2^s), registered.
module hbi_mul_unit (
  input  logic               clk,
  input  logic signed [32:0] x,
  input  logic        [30:0] c,
  input  logic               half,
  output logic signed [47:0] y
);

  logic signed [64:0] prod;

  assign prod = x * $signed({1'b0, c});

  // Arithmetic shift floors toward minus infinity.
  always_ff @(posedge clk) begin
    if (half) y <= 48'(prod >>> 17);
    else y <= 48'(prod >>> 16);
  end
endmodule

// File: rtl/hermite_body_integrator.sv
// Top level of the Hermite predictor-corrector body store.
//  channel   dir  payload
//  req       in   kind, body, first_xyz, second_xyz, mass
//  rsp       out  out_body, pos_xyz, vel_xyz
//  cfg       in   cfg_we, cfg_index, cfg_data (time_step, gravity)
// Each component is read, put through the products of its kind on the single
// multiplier (none for load, save and unused kinds) and written back. The response is
// offered after the third component, or with zeros for a body out of range; the next
// request is taken only once the response has been accepted.
// After reset the state memories are cleared, one entry per cycle, before the
// first request is taken. A stalled response holds the block.
module hermite_body_integrator #(
  parameter int unsigned NUM_BODIES = hbi_pkg::NumBodiesDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hbi_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [hbi_pkg::CfgDataWidth-1:0]  cfg_data,
  hbi_stream_if.sink                        req,
  hbi_stream_if.source                      rsp
);
  import hbi_pkg::*;

  localparam int unsigned Depth = NUM_BODIES * 3;
  localparam int unsigned MW = $clog2(Depth);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_GM    = 8'b00000100,
    S_READ  = 8'b00001000,
    S_LOAD  = 8'b00010000,
    S_MUL   = 8'b00100000,
    S_WRITE = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  logic [15:0] time_step;
  logic [30:0] gravity;

  // Latched request
  logic [2:0] kind;
  logic [BodyWidth-1:0] body;
  logic signed [31:0] fst [3];
  logic signed [31:0] snd [3];
  logic [30:0] mass;
  logic in_range;

  logic [MW-1:0] clr_addr;
  logic [1:0] comp;
  logic [2:0] step;
  logic [2:0] last_step;
  logic no_mul;

  // Eight state memories: p v a j po vo ao jo.
  logic signed [31:0] mem [8][Depth];
  logic signed [31:0] rd [8];
  logic [MW-1:0] addr;
  logic we;
  logic signed [31:0] wd [8];
  logic [7:0] wmask;

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];

  logic [30:0] gm;
  logic [30:0] c2, c3, c12;
  logic signed [47:0] acc;
  logic signed [31:0] mid;
  logic signed [31:0] fin;

  logic signed [32:0] mx;
  logic [30:0] mc;
  logic mhalf;
  logic signed [47:0] my;

  hbi_mul_unit u_mul (.clk(clk), .x(mx), .c(mc), .half(mhalf), .y(my));

  // Coefficients: from narrow constant products (dt < 2^16).
  logic [31:0] dt2;
  logic [47:0] dt3;
  logic [13:0] q12;
  logic [14:0] q3;
  assign q12 = dt2[31:18];
  assign q3 = dt3[47:33];
  // Divide by three as a reciprocal product; exact for operands below 2^16.
  always_ff @(posedge clk) begin
    dt2 <= 32'(time_step) * 32'(time_step);
    dt3 <= dt2 * 48'(time_step);
    c2  <= 31'(dt2 >> 17);
    c12 <= 31'((32'(q12) * 32'd43691) >> 17);
    c3  <= 31'((32'(q3) * 32'd43691) >> 17);
  end

  assign addr = (state == S_CLEAR) ? clr_addr : MW'(body * 3 + comp);

  // Memory: read registered, one write address.
  always_ff @(posedge clk) begin
    for (int m = 0; m < 8; m++) begin
      if (we && wmask[m]) mem[m][addr] <= wd[m];
      rd[m] <= mem[m][addr];
    end
  end

  assign fin = sat32(acc + my);

  // Multiplier operand selection per step.
  always_comb begin
    mx = '0;
    mc = '0;
    mhalf = 1'b0;
    if (state == S_GM) begin
      mx = $signed({2'b00, gravity});
      mc = mass;
    end else if (state == S_MUL) begin
      case (kind)
        KIND_ACCUM: begin
          mc = gm;
          mx = (step == 3'd0) ? 33'(fst[comp]) : 33'(snd[comp]);
        end
        KIND_PREDICT: begin
          case (step)
            3'd0: begin mx = 33'(rd[1]); mc = 31'(time_step); end
            3'd1: begin mx = 33'(rd[2]); mc = c2; end
            3'd2: begin mx = 33'(rd[3]); mc = c3; end
            3'd3: begin mx = 33'(rd[2]); mc = 31'(time_step); end
            default: begin mx = 33'(rd[3]); mc = c2; end
          endcase
        end
        KIND_CORRECT: begin
          case (step)
            3'd0: begin
              mx = 33'(rd[6]) + 33'(rd[2]); mc = 31'(time_step); mhalf = 1'b1;
            end
            3'd1: begin mx = 33'(rd[7]) - 33'(rd[3]); mc = c12; end
            3'd2: begin mx = 33'(rd[6]) - 33'(rd[2]); mc = c12; end
            default: begin
              mx = 33'(rd[5]) + 33'(mid); mc = 31'(time_step); mhalf = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    no_mul = 1'b0;
    case (kind)
      KIND_ACCUM: last_step = 3'd1;
      KIND_PREDICT: last_step = 3'd4;
      KIND_CORRECT: last_step = 3'd3;
      default: begin
        last_step = 3'd0;
        no_mul = 1'b1;
      end
    endcase
  end

  // Write data: the last product of a component lands in the write cycle.
  always_comb begin
    we = (state == S_CLEAR) || (state == S_WRITE);
    wmask = 8'hff;
    for (int m = 0; m < 8; m++) wd[m] = '0;
    if (state == S_WRITE) begin
      wmask = '0;
      case (kind)
        KIND_LOAD: begin
          wmask = 8'b00000011; wd[0] = fst[comp]; wd[1] = snd[comp];
        end
        KIND_ACCUM: begin wmask = 8'b00001100; wd[2] = mid; wd[3] = fin; end
        KIND_PREDICT: begin wmask = 8'b00000011; wd[0] = mid; wd[1] = fin; end
        KIND_CORRECT: begin wmask = 8'b00000011; wd[0] = fin; wd[1] = mid; end
        KIND_SAVE: begin
          wmask = 8'hfc;
          wd[4] = rd[0]; wd[5] = rd[1]; wd[6] = rd[2]; wd[7] = rd[3];
        end
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data.out_body = body;
  assign rsp.data.pos_x = pos[0];
  assign rsp.data.pos_y = pos[1];
  assign rsp.data.pos_z = pos[2];
  assign rsp.data.vel_x = vel[0];
  assign rsp.data.vel_y = vel[1];
  assign rsp.data.vel_z = vel[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      time_step <= TimeStepReset;
      gravity <= GravityReset;
      comp <= '0;
      step <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP: time_step <= cfg_data[15:0];
          REG_GRAVITY: gravity <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == MW'(Depth - 1)) state <= S_IDLE;
          else clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: if (req.valid) begin
          kind <= req.data.kind;
          body <= req.data.body;
          fst[0] <= req.data.first_x; fst[1] <= req.data.first_y;
          fst[2] <= req.data.first_z;
          snd[0] <= req.data.second_x; snd[1] <= req.data.second_y;
          snd[2] <= req.data.second_z;
          mass <= req.data.mass;
          in_range <= (32'(req.data.body) < NUM_BODIES);
          comp <= '0;
          step <= '0;
          state <= S_GM;
        end
        S_GM: state <= S_READ;
        S_READ: begin
          // G*mass sits on the multiplier output only on the first pass.
          if (comp == 2'd0) begin
            if (my > 48'sh7fffffff) gm <= 31'h7fffffff;
            else gm <= my[30:0];
          end
          if (in_range) state <= S_LOAD;
          else begin
            for (int k = 0; k < 3; k++) begin
              pos[k] <= '0; vel[k] <= '0;
            end
            state <= S_OUT;
          end
        end
        S_LOAD: begin
          // Read data now valid; seed the sum.
          case (kind)
            KIND_ACCUM: acc <= 48'(rd[2]);
            KIND_PREDICT: acc <= 48'(rd[0]);
            KIND_CORRECT: acc <= 48'(rd[5]);
            default: acc <= '0;
          endcase
          step <= '0;
          state <= no_mul ? S_WRITE : S_MUL;
        end
        S_MUL: begin
          step <= step + 1'b1;
          case (kind)
            KIND_ACCUM: begin
              if (step == 3'd1) begin
                mid <= fin;
                acc <= 48'(rd[3]);
              end
            end
            KIND_PREDICT: begin
              if (step == 3'd3) begin
                mid <= fin;
                acc <= 48'(rd[1]);
              end else if (step != 3'd0) acc <= acc + my;
            end
            KIND_CORRECT: begin
              // Hold the new velocity, then sum the position terms.
              if (step == 3'd2) begin
                mid <= fin;
                acc <= 48'(rd[4]);
              end else if (step != 3'd0) acc <= acc + my;
            end
            default: ;
          endcase
          if (step == last_step) state <= S_WRITE;
        end
        S_WRITE: begin
          case (kind)
            KIND_LOAD: begin pos[comp] <= fst[comp]; vel[comp] <= snd[comp]; end
            KIND_PREDICT: begin pos[comp] <= mid; vel[comp] <= fin; end
            KIND_CORRECT: begin pos[comp] <= fin; vel[comp] <= mid; end
            default: begin pos[comp] <= rd[0]; vel[comp] <= rd[1]; end
          endcase
          if (comp == 2'd2) begin
            comp <= '0;
            state <= S_OUT;
          end else begin
            comp <= comp + 1'b1;
            state <= S_READ;
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: bench/hbi_tb_types_pkg.sv
// Request and response layouts of the body store channels.
package hbi_tb_types_pkg;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         body;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        mass;
  } body_request_t;

  typedef struct packed {
    logic [5:0]         out_body;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } body_state_t;

endpackage

// File: bench/hbi_integrator_checker.sv
// Predicts body state updates and compares every response with them.
module hbi_integrator_checker
  import hbi_pkg::*;
  import hbi_tb_types_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     req_valid,
  input  logic                     req_ready,
  input  body_request_t            req_data,
  input  logic                     rsp_valid,
  input  logic                     rsp_ready,
  input  body_state_t              rsp_data,
  output int                       fail_count,
  output int                       pending
);

  logic [15:0] step_dt;
  logic [30:0] grav_const;
  logic signed [31:0] pos_m[64][3];
  logic signed [31:0] vel_m[64][3];
  logic signed [31:0] acc_m[64][3];
  logic signed [31:0] jrk_m[64][3];
  logic signed [31:0] pos_old[64][3];
  logic signed [31:0] vel_old[64][3];
  logic signed [31:0] acc_old[64][3];
  logic signed [31:0] jrk_old[64][3];
  body_state_t expected_states[$];

  function automatic longint scaled(longint x, longint c, int s);
    return (x * c) >>> s;
  endfunction

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic body_state_t advance_body(body_request_t r);
    longint dt, c2, c3, c12, gm, p, v, a, j, po, vo, ao, jo;
    longint fst[3];
    longint snd[3];
    logic signed [31:0] vn;
    body_state_t res;
    int b;
    b = r.body;
    dt = longint'(step_dt);
    c2 = (dt * dt) >>> 17;
    c3 = (dt * dt * dt) / (64'sd6 <<< 32);
    c12 = (dt * dt) / (64'sd12 <<< 16);
    fst[0] = r.first_x;  fst[1] = r.first_y;  fst[2] = r.first_z;
    snd[0] = r.second_x; snd[1] = r.second_y; snd[2] = r.second_z;
    if (r.kind == KIND_ACCUM) begin
      gm = (longint'(grav_const) * longint'(r.mass)) >>> 16;
      if (gm > 64'sd2147483647) gm = 64'sd2147483647;
      for (int k = 0; k < 3; k++) begin
        acc_m[b][k] = clip(longint'(acc_m[b][k]) + scaled(fst[k], gm, 16));
        jrk_m[b][k] = clip(longint'(jrk_m[b][k]) + scaled(snd[k], gm, 16));
      end
    end
    for (int k = 0; k < 3; k++) begin
      p = pos_m[b][k]; v = vel_m[b][k]; a = acc_m[b][k]; j = jrk_m[b][k];
      po = pos_old[b][k]; vo = vel_old[b][k]; ao = acc_old[b][k]; jo = jrk_old[b][k];
      case (r.kind)
        KIND_LOAD: begin
          pos_m[b][k] = clip(fst[k]);
          vel_m[b][k] = clip(snd[k]);
        end
        KIND_PREDICT: begin
          pos_m[b][k] = clip(p + scaled(v, dt, 16) + scaled(a, c2, 16) + scaled(j, c3, 16));
          vel_m[b][k] = clip(v + scaled(a, dt, 16) + scaled(j, c2, 16));
        end
        KIND_CORRECT: begin
          vn = clip(vo + scaled(ao + a, dt, 17) + scaled(jo - j, c12, 16));
          vel_m[b][k] = vn;
          pos_m[b][k] = clip(po + scaled(vo + longint'(vn), dt, 17) +
                             scaled(ao - a, c12, 16));
        end
        KIND_SAVE: begin
          pos_old[b][k] = pos_m[b][k];
          vel_old[b][k] = vel_m[b][k];
          acc_old[b][k] = acc_m[b][k];
          jrk_old[b][k] = jrk_m[b][k];
          acc_m[b][k] = '0;
          jrk_m[b][k] = '0;
        end
        default: ;
      endcase
    end
    res.out_body = r.body;
    res.pos_x = pos_m[b][0]; res.pos_y = pos_m[b][1]; res.pos_z = pos_m[b][2];
    res.vel_x = vel_m[b][0]; res.vel_y = vel_m[b][1]; res.vel_z = vel_m[b][2];
    return res;
  endfunction

  assign pending = expected_states.size();

  always @(posedge clk) begin
    body_state_t want;
    if (rst) begin
      step_dt <= TimeStepReset;
      grav_const <= GravityReset;
      fail_count <= 0;
      expected_states.delete();
      for (int b = 0; b < 64; b++) begin
        for (int k = 0; k < 3; k++) begin
          pos_m[b][k] = '0; vel_m[b][k] = '0; acc_m[b][k] = '0; jrk_m[b][k] = '0;
          pos_old[b][k] = '0; vel_old[b][k] = '0; acc_old[b][k] = '0;
          jrk_old[b][k] = '0;
        end
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TIME_STEP) step_dt <= cfg_data[15:0];
        else if (cfg_index == REG_GRAVITY) grav_const <= cfg_data;
      end
      if (req_valid && req_ready) expected_states = {expected_states, advance_body(req_data)};
      if (rsp_valid && rsp_ready) begin
        if (expected_states.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected response: %h", rsp_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_states.pop_front();
          if (want !== rsp_data) begin
            if (fail_count < 10) begin
              $display("mismatch body %0d: expected pos %h %h %h vel %h %h %h",
                       want.out_body, want.pos_x, want.pos_y, want.pos_z,
                       want.vel_x, want.vel_y, want.vel_z);
              $display("  got body %0d: pos %h %h %h vel %h %h %h",
                       rsp_data.out_body, rsp_data.pos_x, rsp_data.pos_y,
                       rsp_data.pos_z, rsp_data.vel_x, rsp_data.vel_y, rsp_data.vel_z);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/hermite_body_integrator_tb.sv
// Stimulus and verdict for the Hermite body store.
module hermite_body_integrator_tb;
  import hbi_pkg::*;
  import hbi_tb_types_pkg::*;

  localparam int CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 0;

  hbi_stream_if #(.payload_t(body_request_t)) req_ch ();
  hbi_stream_if #(.payload_t(body_state_t)) rsp_ch ();

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  hermite_body_integrator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  hbi_integrator_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_valid(req_ch.valid), .req_ready(req_ch.ready),
    .req_data(req_ch.data), .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
    .rsp_data(rsp_ch.data), .fail_count(fail_count), .pending(pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stall pattern drawn at random from four modes, with two long hold-offs.
  always @(posedge clk) begin
    int rx_cycle;
    int hold_left;
    int rx_mode;
    if (rst) begin
      rx_cycle = 0;
      hold_left = 0;
      rx_mode = 0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 4000 || rx_cycle == 30000) hold_left = 400;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h003fffff)) - 32'sd2097152;
    endcase
  endfunction

  function automatic body_request_t make_request(logic [2:0] kind, logic [5:0] body);
    body_request_t r;
    r.kind = kind;
    r.body = body;
    r.first_x = rand_q(); r.first_y = rand_q(); r.first_z = rand_q();
    r.second_x = rand_q(); r.second_y = rand_q(); r.second_z = rand_q();
    case ($urandom_range(0, 5))
      0: r.mass = 31'h7fffffff;
      1: r.mass = '0;
      2: r.mass = 31'($urandom);
      default: r.mass = 31'($urandom_range(0, 32'h0003ffff));
    endcase
    return r;
  endfunction

  // Offer one request and hold it until taken; the sender runs in bursts.
  task automatic offer(body_request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Well-formed Hermite step sequences, mostly on bodies 0 to 7, with some noise.
  task automatic random_phase(int count);
    int sent;
    logic [5:0] b;
    sent = 0;
    while (sent < count) begin
      b = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 2) == 0) begin
          offer(make_request(KIND_LOAD, b)); sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          offer(make_request(KIND_ACCUM, b)); sent++;
        end
        offer(make_request(KIND_SAVE, b)); sent++;
        offer(make_request(KIND_PREDICT, b)); sent++;
        repeat ($urandom_range(1, 3)) begin
          offer(make_request(KIND_ACCUM, b)); sent++;
        end
        offer(make_request(KIND_CORRECT, b)); sent++;
      end else begin
        offer(make_request(3'($urandom_range(0, 7)), b)); sent++;
      end
    end
  endtask

  initial begin
    body_request_t r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the fields, every kind, and the unused kind codes.
    r = make_request(KIND_LOAD, 6'd0);
    r.first_x = 32'sh7fffffff; r.first_y = 32'sh80000000; r.first_z = 32'sh7fffffff;
    r.second_x = 32'sh80000000; r.second_y = 32'sh7fffffff; r.second_z = 32'sh80000000;
    offer(r);
    r.kind = KIND_ACCUM; r.mass = 31'h7fffffff;
    offer(r);
    offer(r);
    r.mass = '0;
    offer(r);
    offer(make_request(KIND_PREDICT, 6'd0));
    offer(make_request(KIND_SAVE, 6'd0));
    offer(make_request(KIND_CORRECT, 6'd0));
    offer(make_request(KIND_CORRECT, 6'd63));
    r = make_request(KIND_LOAD, 6'd63);
    r.first_x = '0; r.second_z = -32'sd1;
    offer(r);
    offer(make_request(KIND_ACCUM, 6'd63));
    offer(make_request(KIND_PREDICT, 6'd63));
    offer(make_request(3'd5, 6'd63));
    offer(make_request(3'd6, 6'd0));
    offer(make_request(3'd7, 6'd42));
    offer(make_request(KIND_SAVE, 6'd63));
    offer(make_request(KIND_CORRECT, 6'd63));
    random_phase(400);
    drain();

    write_reg(REG_TIME_STEP, 31'h0000ffff);
    write_reg(REG_GRAVITY, 31'h7fffffff);
    random_phase(350);
    drain();

    write_reg(REG_TIME_STEP, '0);
    write_reg(REG_GRAVITY, '0);
    random_phase(300);
    drain();

    write_reg(REG_TIME_STEP, 31'($urandom_range(1, 65534)));
    write_reg(REG_GRAVITY, 31'($urandom_range(1, 32'h0004ffff)));
    random_phase(400);
    drain();

    write_reg(REG_TIME_STEP, 31'd655);
    write_reg(REG_GRAVITY, 31'd65536);
    random_phase(350);
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
